>>> rtl/assert_macros.svh
// Assertion helper macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/spht_pkg.sv
// Package: types, codes and constants of the step profile thermostat.
`default_nettype none

package spht_pkg;

	localparam int NUM_INTERVALS = 4;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PREP = 2'd1,
		PH_HOLD = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	localparam logic [1:0] MODE_HEAT = 2'd1;
	localparam logic [1:0] MODE_COOL = 2'd2;

	typedef enum logic [2:0] {
		REG_WORD0      = 3'd0,
		REG_WORD1      = 3'd1,
		REG_WORD2      = 3'd2,
		REG_WORD3      = 3'd3,
		REG_HIGH_GATE  = 3'd4,
		REG_LOW_GATE   = 3'd5,
		REG_PREP_LIMIT = 3'd6
	} cfg_reg_t;

	localparam logic [7:0]  HIGH_GATE_RST  = 8'd2;
	localparam logic [7:0]  LOW_GATE_RST   = 8'd2;
	localparam logic [15:0] PREP_LIMIT_RST = 16'd3600;

	// Packing of one interval word: duration, target, mode (LSBs).
	typedef struct packed {
		logic [15:0] duration;
		logic [15:0] target;
		logic [1:0]  mode;
	} interval_t;

	typedef struct packed {
		logic clamp;
		logic hlamp;
		logic cooler;
		logic heater;
	} drive_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  idx;
		logic        hold_active;
		logic [15:0] prep_ticks;
		logic [15:0] remaining;
		drive_t      drive;
	} ctrl_state_t;

	typedef struct packed {
		logic        start_req;
		logic [15:0] temperature;
	} in_item_t;

	typedef struct packed {
		logic        heater_on;
		logic        cooler_on;
		logic        heat_lamp;
		logic        cool_lamp;
		logic [1:0]  phase;
		logic [1:0]  interval_now;
		logic [15:0] ticks_left;
	} out_item_t;

	// Gate settings handed to the tick logic.
	typedef struct packed {
		logic [7:0]  high_gate;
		logic [7:0]  low_gate;
		logic [15:0] prep_limit;
	} gates_t;

endpackage

`default_nettype wire

>>> rtl/step_profile_hysteresis_thermostat.sv
// Top level: step profile thermostat with hysteresis, one tick per transfer.
//
// Usage notes
//  - in channel: one transfer per one-second tick, carrying start_req and the
//    temperature sample. A transfer happens when in_valid is high and
//    in_stall is low.
//  - out channel: exactly one result per input transfer, in order, holding
//    the drive bits, phase, interval index and hold ticks left after the tick.
//  - cfg channel: cfg_ready is always high; index 0..3 are the interval
//    words, 4 high gate, 5 low gate, 6 prep tick limit; other indexes are
//    dropped. Write only while no tick is in flight.
//  - Path: a transfer loads the input register; the tick's result is loaded
//    into the result register when the path advances, and so shows on out.
//  - Throughput: one tick per cycle unless a held result is refused; the
//    single compare/update pass between the input and result registers sets it.
//  - Stall: while a result sits in the output register with out_stall high,
//    the whole two-stage path holds and in_stall is raised; a result being
//    taken frees the path for a new transfer in the same cycle.
//  - Reset (arst_n low): phase idle, interval 0, all drives off, gates 2/2,
//    prep limit 3600, interval words zero, both stages empty.
`default_nettype none
`include "assert_macros.svh"

module step_profile_hysteresis_thermostat (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// tick input
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire spht_pkg::in_item_t  in_data,
	// result output
	output logic                     out_valid,
	input  wire logic                out_stall,
	output spht_pkg::out_item_t      out_data,
	// configuration writes
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [33:0]         cfg_data
);

	// Config registers
	spht_pkg::interval_t  word0_q, word1_q, word2_q, word3_q;
	spht_pkg::gates_t     gates_q;

	// Controller state
	spht_pkg::ctrl_state_t st_q;
	spht_pkg::ctrl_state_t st_nx;

	// Pipeline
	logic                  valid_s1;
	spht_pkg::in_item_t    item_s1;
	logic                  out_valid_q;
	spht_pkg::out_item_t   out_q;

	spht_pkg::interval_t   cur_iv;
	spht_pkg::interval_t   nxt_iv;
	logic [1:0]            idx_inc;
	logic                  advance;
	logic                  cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Path moves unless a held result is being refused.
	assign advance  = !(out_valid_q && out_stall);
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word0_q          <= '0;
			word1_q          <= '0;
			word2_q          <= '0;
			word3_q          <= '0;
			gates_q.high_gate  <= spht_pkg::HIGH_GATE_RST;
			gates_q.low_gate   <= spht_pkg::LOW_GATE_RST;
			gates_q.prep_limit <= spht_pkg::PREP_LIMIT_RST;
		end else if (cfg_we) begin
			case (spht_pkg::cfg_reg_t'(cfg_index))
				spht_pkg::REG_WORD0:      word0_q <= cfg_data;
				spht_pkg::REG_WORD1:      word1_q <= cfg_data;
				spht_pkg::REG_WORD2:      word2_q <= cfg_data;
				spht_pkg::REG_WORD3:      word3_q <= cfg_data;
				spht_pkg::REG_HIGH_GATE:  gates_q.high_gate  <= cfg_data[7:0];
				spht_pkg::REG_LOW_GATE:   gates_q.low_gate   <= cfg_data[7:0];
				spht_pkg::REG_PREP_LIMIT: gates_q.prep_limit <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Current interval and the one after it (next wraps, unused on the last).
	assign idx_inc = st_q.idx + 2'd1;

	always_comb begin
		case (st_q.idx)
			2'd0:    cur_iv = word0_q;
			2'd1:    cur_iv = word1_q;
			2'd2:    cur_iv = word2_q;
			default: cur_iv = word3_q;
		endcase
	end

	always_comb begin
		case (idx_inc)
			2'd0:    nxt_iv = word0_q;
			2'd1:    nxt_iv = word1_q;
			2'd2:    nxt_iv = word2_q;
			default: nxt_iv = word3_q;
		endcase
	end

	spht_step u_step (
		.st       (st_q),
		.item     (item_s1),
		.cur_iv   (cur_iv),
		.nxt_iv   (nxt_iv),
		.first_iv (word0_q),
		.gates    (gates_q),
		.st_nx    (st_nx)
	);

	// Control: valid bits and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			st_q        <= '{phase: spht_pkg::PH_IDLE, idx: 2'd0, hold_active: 1'b0,
				prep_ticks: 16'd0, remaining: 16'd0, drive: '0};
		end else if (advance) begin
			valid_s1    <= in_valid;
			out_valid_q <= valid_s1;
			if (valid_s1)
				st_q <= st_nx;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (advance && in_valid)
			item_s1 <= in_data;
		if (advance && valid_s1) begin
			out_q.heater_on    <= st_nx.drive.heater;
			out_q.cooler_on    <= st_nx.drive.cooler;
			out_q.heat_lamp    <= st_nx.drive.hlamp;
			out_q.cool_lamp    <= st_nx.drive.clamp;
			out_q.phase        <= st_nx.phase;
			out_q.interval_now <= st_nx.idx;
			out_q.ticks_left   <= st_nx.remaining;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ASSERT_CLK(a_idle_drives_off, clk, arst_n, (st_q.phase == spht_pkg::PH_IDLE) |-> (st_q.drive == '0), "drives on while idle")
	`ASSERT_CLK(a_done_drives_off, clk, arst_n, (st_q.phase == spht_pkg::PH_DONE) |-> (st_q.drive == '0), "drives on after profile end")
	`ASSERT_CLK(a_hold_no_cooler, clk, arst_n, (st_q.phase == spht_pkg::PH_HOLD) |-> !st_q.drive.cooler, "cooler driven in hold")
	`ASSERT_NEVER(a_heat_and_cool, clk, arst_n, st_q.drive.heater && st_q.drive.cooler && (st_q.phase == spht_pkg::PH_PREP), "heater and cooler both on in prep")

endmodule

`default_nettype wire

>>> rtl/spht_step.sv
// Per-tick next-state logic of the thermostat controller.
`default_nettype none

module spht_step (
	input  wire spht_pkg::ctrl_state_t st,
	input  wire spht_pkg::in_item_t    item,
	input  wire spht_pkg::interval_t   cur_iv,
	input  wire spht_pkg::interval_t   nxt_iv,
	input  wire spht_pkg::interval_t   first_iv,
	input  wire spht_pkg::gates_t      gates,
	output spht_pkg::ctrl_state_t      st_nx
);

	function automatic spht_pkg::ctrl_state_t prep_state(
		input spht_pkg::ctrl_state_t s,
		input logic [1:0]            idx,
		input spht_pkg::interval_t   iv
	);
		spht_pkg::ctrl_state_t r;
		r             = s;
		r.phase       = spht_pkg::PH_PREP;
		r.idx         = idx;
		r.prep_ticks  = '0;
		r.hold_active = 1'b0;
		r.remaining   = iv.duration;
		r.drive       = '0;
		if (iv.mode == spht_pkg::MODE_HEAT) begin
			r.drive.heater = 1'b1;
			r.drive.hlamp  = 1'b1;
		end else if (iv.mode == spht_pkg::MODE_COOL) begin
			r.drive.cooler = 1'b1;
			r.drive.clamp  = 1'b1;
		end
		return r;
	endfunction

	function automatic spht_pkg::ctrl_state_t end_interval(
		input spht_pkg::ctrl_state_t s,
		input spht_pkg::interval_t   iv
	);
		spht_pkg::ctrl_state_t r;
		logic [2:0]            idx_inc;
		r             = s;
		r.drive       = '0;
		r.hold_active = 1'b0;
		idx_inc       = {1'b0, s.idx} + 3'd1;
		if (idx_inc >= 3'(spht_pkg::NUM_INTERVALS))
			r.phase = spht_pkg::PH_DONE;
		else
			r = prep_state(r, idx_inc[1:0], iv);
		return r;
	endfunction

	logic signed [17:0] temp_s;
	logic signed [17:0] hi_s;
	logic signed [17:0] lo_s;
	logic               mode_active;

	// Signed thresholds; lower one may go negative.
	assign temp_s = signed'({2'b00, item.temperature});
	assign hi_s   = signed'({2'b00, cur_iv.target}) + signed'({10'b0, gates.high_gate});
	assign lo_s   = signed'({2'b00, cur_iv.target}) - signed'({10'b0, gates.low_gate});
	assign mode_active = (cur_iv.mode == spht_pkg::MODE_HEAT) ||
		(cur_iv.mode == spht_pkg::MODE_COOL);

	always_comb begin
		st_nx = st;
		case (st.phase)
			spht_pkg::PH_IDLE, spht_pkg::PH_DONE: begin
				if (item.start_req)
					st_nx = prep_state(st, 2'd0, first_iv);
			end
			spht_pkg::PH_PREP: begin
				if (temp_s > hi_s || st.prep_ticks >= gates.prep_limit) begin
					st_nx.drive.heater = 1'b0;
					st_nx.drive.cooler = 1'b0;
					st_nx.hold_active  = 1'b0;
					st_nx.phase        = spht_pkg::PH_HOLD;
					if (st.remaining == 16'd0)
						st_nx = end_interval(st_nx, nxt_iv);
				end else begin
					st_nx.prep_ticks = st.prep_ticks + 16'd1;
				end
			end
			spht_pkg::PH_HOLD: begin
				if (mode_active) begin
					if (temp_s >= hi_s && st_nx.hold_active) begin
						st_nx.hold_active  = 1'b0;
						st_nx.drive.heater = 1'b0;
					end
					if (temp_s <= lo_s && !st_nx.hold_active) begin
						st_nx.hold_active  = 1'b1;
						st_nx.drive.heater = 1'b1;
					end
				end
				if (st.remaining != 16'd0)
					st_nx.remaining = st.remaining - 16'd1;
				if (st_nx.remaining == 16'd0)
					st_nx = end_interval(st_nx, nxt_iv);
			end
			default: begin
				st_nx = st;
			end
		endcase
	end

endmodule

`default_nettype wire
